// ----- src/sfpq_pkg.sv -----
// sfpq_pkg: shared types and constants for the smallest-first pending queue
// used by sfpq_cell and smallest_first_pending_queue_unit; no dependencies
package sfpq_pkg;

    localparam int SIZE_W              = 32;
    localparam int ID_W                = 16;
    localparam int DEFAULT_QUEUE_DEPTH = 16;

    // transaction kinds carried on the input tuser
    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_TAKE = 1'b1;

    // one queue entry
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [ID_W-1:0]   id;
    } entry_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic add;
        logic take;
    } cmd_t;

endpackage

// ----- src/sfpq_cell.sv -----
// sfpq_cell: one slot of the sorted queue chain, holding one entry
// depends on sfpq_pkg for entry and command types
module sfpq_cell (
    input  logic             clk,
    input  sfpq_pkg::cmd_t   cmd,        // broadcast add / take
    input  sfpq_pkg::entry_t new_entry,  // entry being inserted
    input  logic             occupied,   // slot lies below the fill count
    input  logic             left_keep,  // left neighbour keeps its entry
    input  sfpq_pkg::entry_t left_entry, // entry of the cell nearer the head
    input  sfpq_pkg::entry_t right_entry,// entry of the cell nearer the tail
    output sfpq_pkg::entry_t entry,      // this cell's entry
    output logic             keep        // this cell stays put on an add
);
    import sfpq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // an occupied entry no larger than the new size stays ahead of it
    assign keep  = occupied && (entry_reg.size <= new_entry.size);
    assign entry = entry_reg;

    // insert: hold, take the new entry, or shift in from the left; take: shift in from the right
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.add)
        begin
            if (keep)
            begin
                entry_next = entry_reg;
            end
            else if (left_keep)
            begin
                entry_next = new_entry;
            end
            else
            begin
                entry_next = left_entry;
            end
        end
        else if (cmd.take)
        begin
            entry_next = right_entry;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- src/smallest_first_pending_queue_unit.sv -----
// smallest_first_pending_queue_unit: top level of the sorted pending queue
// depends on sfpq_pkg and sfpq_cell
// the result of an accepted transaction sits in the output register from the next cycle
// one add or take per cycle through a parallel compare and shift across the cell
// chain; input stalls while a result waits unaccepted
// reset clears the fill count, the id counter and the output valid; entry
// registers are not reset
module smallest_first_pending_queue_unit #(
    parameter int QUEUE_DEPTH = sfpq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1),
    parameter int OUT_DW      = ((sfpq_pkg::ID_W + sfpq_pkg::SIZE_W + CNT_W + 7) / 8) * 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [sfpq_pkg::SIZE_W-1:0] s_tdata,  // [31:0] file_size
    input  logic                        s_tuser,  // [0] mode
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [OUT_DW-1:0]           m_tdata,  // taken_id, taken_size, pending_count, zero pad
    output logic [1:0]                  m_tuser   // [0] taken_valid, [1] overflow
);
    import sfpq_pkg::*;

    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [ID_W-1:0]  last_id_reg, last_id_next;
    logic             out_valid_reg, out_valid_next;
    logic             taken_valid_reg, taken_valid_next;
    logic             overflow_reg, overflow_next;
    logic [ID_W-1:0]  taken_id_reg, taken_id_next;
    logic [SIZE_W-1:0] taken_size_reg, taken_size_next;
    logic [CNT_W-1:0] pending_reg, pending_next;

    logic             accept;
    logic             is_add;
    logic             full;
    logic             empty;
    logic [ID_W-1:0]  new_id;
    cmd_t             cmd;
    entry_t           new_entry;
    entry_t           cell_entry [QUEUE_DEPTH];
    logic             cell_keep  [QUEUE_DEPTH];

    // input handshake: take a transaction when the output slot frees up
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_add   = (s_tuser == MODE_ADD);
    assign full     = (occ_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (occ_reg == '0);
    assign new_id   = last_id_reg + ID_W'(1);

    // command broadcast to the chain
    assign cmd.add        = accept && is_add && !full;
    assign cmd.take       = accept && !is_add && !empty;
    assign new_entry.size = s_tdata;
    assign new_entry.id   = new_id;

    // chain of cells, head at index 0
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        entry_t left_e;
        entry_t right_e;
        logic   left_k;

        if (i == 0)
        begin : g_head
            assign left_e = new_entry;
            assign left_k = 1'b1;
        end
        else
        begin : g_mid
            assign left_e = cell_entry[i-1];
            assign left_k = cell_keep[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_e = cell_entry[i];
        end
        else
        begin : g_body
            assign right_e = cell_entry[i+1];
        end

        sfpq_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .new_entry   (new_entry),
            .occupied    (occ_reg > CNT_W'(i)),
            .left_keep   (left_k),
            .left_entry  (left_e),
            .right_entry (right_e),
            .entry       (cell_entry[i]),
            .keep        (cell_keep[i])
        );
    end

    // fill count, id counter and result formation
    always_comb
    begin
        occ_next          = occ_reg;
        last_id_next      = last_id_reg;
        out_valid_next    = out_valid_reg;
        taken_valid_next  = taken_valid_reg;
        overflow_next     = overflow_reg;
        taken_id_next     = taken_id_reg;
        taken_size_next   = taken_size_reg;
        pending_next      = pending_reg;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            out_valid_next   = 1'b1;
            taken_valid_next = 1'b0;
            overflow_next    = 1'b0;
            taken_id_next    = '0;
            taken_size_next  = '0;
            if (cmd.add)
            begin
                occ_next      = occ_reg + CNT_W'(1);
                last_id_next  = new_id;
                taken_id_next = new_id;
            end
            else if (cmd.take)
            begin
                occ_next         = occ_reg - CNT_W'(1);
                taken_valid_next = 1'b1;
                taken_id_next    = cell_entry[0].id;
                taken_size_next  = cell_entry[0].size;
            end
            else if (is_add)
            begin
                overflow_next = 1'b1;
            end
            pending_next = occ_next;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            last_id_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            last_id_reg   <= last_id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload registers
    always_ff @(posedge clk)
    begin
        taken_valid_reg <= taken_valid_next;
        overflow_reg    <= overflow_next;
        taken_id_reg    <= taken_id_next;
        taken_size_reg  <= taken_size_next;
        pending_reg     <= pending_next;
    end

    // output transaction packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DW'({pending_reg, taken_size_reg, taken_id_reg});
    assign m_tuser  = {overflow_reg, taken_valid_reg};

endmodule

// ----- tb/pending_queue_checker.sv -----
`timescale 1ns / 1ps
// pending_queue_checker: watches both stream channels of the smallest-first queue,
// keeps its own sorted copy of the pending files and checks every result against it
// depends on sfpq_pkg
module pending_queue_checker #(
    parameter int QUEUE_DEPTH = sfpq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1),
    parameter int OUT_DW      = ((sfpq_pkg::ID_W + sfpq_pkg::SIZE_W + CNT_W + 7) / 8) * 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [sfpq_pkg::SIZE_W-1:0] s_tdata,   // [31:0] file_size
    input  logic                        s_tuser,   // [0] mode
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [OUT_DW-1:0]           m_tdata,   // taken_id, taken_size, pending_count, pad
    input  logic [1:0]                  m_tuser,   // [0] taken_valid, [1] overflow
    output int                          fail_total,
    output int                          results_due
);
    import sfpq_pkg::*;

    typedef struct packed {
        logic              taken_valid;
        logic [ID_W-1:0]   taken_id;
        logic [SIZE_W-1:0] taken_size;
        logic              overflow;
        logic [CNT_W-1:0]  pending_count;
    } queue_outcome_t;

    // shadow of the pending files, head (smallest) first
    entry_t          shadow_entries [QUEUE_DEPTH];
    int              shadow_fill;
    logic [ID_W-1:0] shadow_last_id;
    queue_outcome_t  awaited_outcomes [$];
    queue_outcome_t  predicted;
    int              mismatch_count;

    assign fail_total = mismatch_count;

    // shortest-job-first update of the shadow queue for one accepted transaction
    function automatic queue_outcome_t sjf_outcome(input logic mode,
                                                   input logic [SIZE_W-1:0] size);
        queue_outcome_t res;
        int             slot;
        int             k;
        res = '0;
        if (mode == MODE_ADD) begin
            if (shadow_fill >= QUEUE_DEPTH) begin
                res.overflow = 1'b1;
            end
            else begin
                // new file goes behind every entry of equal or smaller size
                slot = 0;
                while (slot < shadow_fill && shadow_entries[slot].size <= size)
                    slot++;
                for (k = shadow_fill; k > slot; k--)
                    shadow_entries[k] = shadow_entries[k-1];
                shadow_last_id             = shadow_last_id + 1'b1;
                shadow_entries[slot].size = size;
                shadow_entries[slot].id   = shadow_last_id;
                shadow_fill++;
                res.taken_id = shadow_last_id;
            end
        end
        else if (shadow_fill > 0) begin
            res.taken_valid = 1'b1;
            res.taken_id    = shadow_entries[0].id;
            res.taken_size  = shadow_entries[0].size;
            for (k = 1; k < shadow_fill; k++)
                shadow_entries[k-1] = shadow_entries[k];
            shadow_fill--;
        end
        res.pending_count = CNT_W'(shadow_fill);
        return res;
    endfunction

    task automatic check_field(input string label, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    task automatic compare_outcome();
        queue_outcome_t want;
        queue_outcome_t got;
        if (awaited_outcomes.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual tdata %0h tuser %0h",
                     $time, m_tdata, m_tuser);
            mismatch_count++;
        end
        else begin
            want               = awaited_outcomes.pop_front();
            got.taken_valid    = m_tuser[0];
            got.overflow       = m_tuser[1];
            got.taken_id       = m_tdata[ID_W-1:0];
            got.taken_size     = m_tdata[ID_W +: SIZE_W];
            got.pending_count  = m_tdata[ID_W+SIZE_W +: CNT_W];
            check_field("taken_valid", 64'(want.taken_valid), 64'(got.taken_valid));
            check_field("taken_id", 64'(want.taken_id), 64'(got.taken_id));
            check_field("taken_size", 64'(want.taken_size), 64'(got.taken_size));
            check_field("overflow", 64'(want.overflow), 64'(got.overflow));
            check_field("pending_count", 64'(want.pending_count), 64'(got.pending_count));
        end
    endtask

    // results are checked before the same edge's input transaction is predicted
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            shadow_fill    = 0;
            shadow_last_id = '0;
            mismatch_count = 0;
            awaited_outcomes.delete();
            results_due   <= 0;
        end
        else begin
            if (m_tvalid && m_tready)
                compare_outcome();
            if (s_tvalid && s_tready) begin
                predicted        = sjf_outcome(s_tuser, s_tdata);
                awaited_outcomes = {awaited_outcomes, predicted};
            end
            results_due <= awaited_outcomes.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for smallest_first_pending_queue_unit
// depends on sfpq_pkg, the unit under test and pending_queue_checker
module tb_top;
    import sfpq_pkg::*;

    localparam int QUEUE_DEPTH     = DEFAULT_QUEUE_DEPTH;
    localparam int CNT_W           = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_DW          = ((ID_W + SIZE_W + CNT_W + 7) / 8) * 8;
    localparam int HOLD_CYCLES     = 300;
    localparam int ITEMS_PER_PHASE = 250;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [SIZE_W-1:0] s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_DW-1:0] m_tdata;
    logic [1:0]        m_tuser;

    int   fail_total;
    int   results_due;
    int   send_idle_pct;
    int   recv_stall_pct;
    logic hold_req;
    logic hold_served = 1'b0;
    int   hold_left = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    smallest_first_pending_queue_unit #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    pending_queue_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_total (fail_total),
        .results_due(results_due)
    );

    // result side: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req && !hold_served) begin
            hold_served <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end
        else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // offer one transaction, after a random idle gap, and wait for its acceptance
    task automatic send_request(input logic mode, input logic [SIZE_W-1:0] size);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= size;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // stop offering and wait until every predicted result has been seen
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (results_due != 0);
    endtask

    // sizes biased towards ties and extremes
    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(15);
            2: return $urandom_range(1) ? '1 : '0;
            default: return $urandom & 32'hF000_000F;
        endcase
    endfunction

    // runs of adds, runs of takes and mixed runs, so the queue swings full and empty
    task automatic run_mix(input int count);
        int   sent;
        int   run_len;
        int   flavour;
        int   k;
        logic mode;
        sent = 0;
        while (sent < count) begin
            run_len = $urandom_range(20, 1);
            flavour = $urandom_range(2);
            for (k = 0; k < run_len; k++) begin
                case (flavour)
                    0: mode = MODE_ADD;
                    1: mode = MODE_TAKE;
                    default: mode = $urandom_range(1) ? MODE_TAKE : MODE_ADD;
                endcase
                send_request(mode, pick_size());
                sent++;
            end
        end
    endtask

    initial
    begin
        int k;
        rst_n          <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= MODE_ADD;
        hold_req       <= 1'b0;
        recv_stall_pct <= 0;
        send_idle_pct   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // take from empty, extremes, ties, then fill to overflow and take twice
        send_request(MODE_TAKE, 32'hFFFF_FFFF);
        send_request(MODE_ADD, 32'hFFFF_FFFF);
        send_request(MODE_ADD, 32'h0000_0000);
        send_request(MODE_ADD, 32'd7);
        send_request(MODE_ADD, 32'd7);
        for (k = 0; k < QUEUE_DEPTH - 4; k++)
            send_request(MODE_ADD, k[0] ? 32'd7 : 32'h8000_0000 - k);
        send_request(MODE_ADD, 32'd1);
        send_request(MODE_TAKE, 32'h0);
        send_request(MODE_TAKE, 32'h5555_AAAA);
        wait_for_drain();

        // long result hold-off while adds keep coming, so the input stalls
        hold_req <= 1'b1;
        for (k = 0; k < 40; k++)
            send_request(MODE_ADD, pick_size());
        wait_for_drain();

        // random phases: none, sender idle, receiver stall, both
        run_mix(ITEMS_PER_PHASE);
        wait_for_drain();
        send_idle_pct   = 64;
        recv_stall_pct <= 0;
        run_mix(ITEMS_PER_PHASE);
        wait_for_drain();
        send_idle_pct   = 0;
        recv_stall_pct <= 64;
        run_mix(ITEMS_PER_PHASE);
        wait_for_drain();
        send_idle_pct   = 30;
        recv_stall_pct <= 30;
        run_mix(ITEMS_PER_PHASE);
        wait_for_drain();

        repeat (10) @(posedge clk);
        if (fail_total == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #8_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
